### src/nsd_pkg.sv
`timescale 1ns / 1ps

package nsd_pkg;

  // fixed field widths
  localparam int POS_W = 32;
  localparam int ACT_W = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_OUT_W = 11;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // item kinds carried on the input tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } act_t;

  // result status carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] key;
  } cell_cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### src/nsd_cell.sv
`timescale 1ns / 1ps

module nsd_cell #(
  parameter int TABLE_DEPTH = nsd_pkg::DEFAULT_TABLE_DEPTH,
  parameter int IDX = 0,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk,
  input  nsd_pkg::cell_cmd_t      cmd,
  input  logic [CNT_W-1:0]        count,
  input  logic [nsd_pkg::POS_W-1:0] prev_value,
  input  logic                    prev_gt,
  input  logic [nsd_pkg::POS_W-1:0] next_value,
  input  logic [nsd_pkg::POS_W-1:0] head_value,
  output logic [nsd_pkg::POS_W-1:0] value,
  output logic                    gt
);
  import nsd_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_IDX_P1 = CNT_W'(IDX + 1);

  logic             valid;
  logic             is_last;
  logic [POS_W-1:0] value_next;

  // occupancy follows from the fill count
  assign valid   = MY_IDX < count;
  assign is_last = MY_IDX_P1 == count;

  // empty cells and larger entries sit at or after the insert point
  assign gt = !valid || (value > cmd.key);

  always_comb begin
    value_next = value;
    case (cmd.op)
      OP_INSERT: begin
        if (gt) begin
          // first cell past the insert point takes the key, the rest shift up
          value_next = prev_gt ? prev_value : cmd.key;
        end
      end
      OP_ROTATE: begin
        // occupied entries move toward the head, head wraps to the tail
        if (is_last) begin
          value_next = head_value;
        end else if (valid) begin
          value_next = next_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### src/nsd_ctrl.sv
`timescale 1ns / 1ps

module nsd_ctrl #(
  parameter int TABLE_DEPTH = nsd_pkg::DEFAULT_TABLE_DEPTH,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [nsd_pkg::ACT_W-1:0]     s_axis_tuser,   // action
  input  logic [nsd_pkg::POS_W-1:0]     s_axis_tdata,   // position
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [nsd_pkg::STATUS_W-1:0]  m_axis_tuser,   // status
  output logic [nsd_pkg::POS_W-1:0]     distance,
  output logic [nsd_pkg::CNT_OUT_W-1:0] stored_count,
  input  logic [nsd_pkg::POS_W-1:0]     head_value,
  output nsd_pkg::cell_cmd_t            cmd,
  output logic [CNT_W-1:0]              count
);
  import nsd_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W-1:0]       remain, remain_next;
  logic [POS_W-1:0]       query_pos;
  logic [POS_W-1:0]       best, best_next;
  logic                   accept;
  logic                   out_free;
  logic                   full;
  logic                   empty;
  act_t                   act;
  logic [POS_W:0]         diff;
  logic [POS_W-1:0]       head_gap;
  logic                   load;
  logic [POS_W-1:0]       res_dist;
  status_t                res_status;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  assign act      = act_t'(s_axis_tuser);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign full     = count == DEPTH_CNT;
  assign empty    = count == '0;

  // distance from the query to the entry now at the head of the chain
  assign diff     = {1'b0, query_pos} - {1'b0, head_value};
  assign head_gap = diff[POS_W] ? (head_value - query_pos) : diff[POS_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && act == ACT_QUERY && !empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (remain == CNT_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and chain command
  always_comb begin
    s_axis_tready = !rst && (state == S_IDLE) && out_free;
    cmd.key = s_axis_tdata;
    cmd.op  = OP_HOLD;
    if (state == S_SCAN) begin
      cmd.op = OP_ROTATE;
    end else if (accept && act == ACT_INSERT && !full) begin
      cmd.op = OP_INSERT;
    end
  end

  // count, scan bookkeeping and result
  always_comb begin
    count_next  = count;
    remain_next = remain;
    best_next   = best;
    load        = 1'b0;
    res_dist    = '0;
    res_status  = ST_DONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (act)
            ACT_CLEAR: count_next = '0;
            ACT_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
            ACT_QUERY: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                load        = 1'b0;
                remain_next = count;
                best_next   = '1;
              end
            end
            default: count_next = count;
          endcase
        end
      end
      S_SCAN: begin
        remain_next = remain - CNT_W'(1);
        if (head_gap < best) begin
          best_next = head_gap;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load     = 1'b1;
          res_dist = best;
        end
      end
      default: load = 1'b0;
    endcase
  end

  assign count_ext = {{CNT_OUT_W{1'b0}}, count_next};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    remain <= remain_next;
    best   <= best_next;
    if (accept) begin
      query_pos <= s_axis_tdata;
    end
    if (load) begin
      distance     <= res_dist;
      m_axis_tuser <= res_status;
      stored_count <= count_ext[CNT_OUT_W-1:0];
    end
  end

  // the table never overfills
  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("entry count above table depth");

  // rotation relies on a fixed fill during the whole scan
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |=> $stable(count))
    else $error("entry count changed during query scan");

  // a scan always has entries left to visit
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |-> remain != '0)
    else $error("query scan with no entries left");

  // an accepted insert into a table with room grows it by one
  assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_INSERT && !full |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  // an empty-table query never enters the scan
  assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_QUERY && empty |=> state == S_IDLE)
    else $error("query on empty table started a scan");

endmodule

### src/nearest_sorted_distance_top.sv
`timescale 1ns / 1ps

// Nearest-distance lookup over a sorted table of up to TABLE_DEPTH unsigned
// 32-bit positions, held in a chain of cells, one entry per cell. An item's
// kind (clear, insert, query) comes on s_axis_tuser and its position on
// s_axis_tdata; each item gives exactly one result beat. An insert compares
// the key in every cell at once and shifts the larger entries one cell up,
// keeping equal entries ahead of the new one. A query rotates the N entries
// of the table past a single subtract-and-compare unit at the head, one per
// cycle, and the table is back in order when the scan ends. A query on an
// empty table answers at once with status 2 and distance 0; an insert into a
// full table is dropped with status 1. A new item is taken only while no
// query scan runs and the output register is empty or its beat is read in
// the same cycle, so a result held by the receiver stalls the input; nothing
// is taken in reset.
module nearest_sorted_distance_top #(
  parameter int TABLE_DEPTH = nsd_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nsd_pkg::POS_W-1:0]      s_axis_tdata,  // [31:0] position
  input  logic [nsd_pkg::ACT_W-1:0]      s_axis_tuser,  // [1:0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // [31:0] distance, [42:32] stored_count
  output logic [nsd_pkg::STATUS_W-1:0]   m_axis_tuser   // [1:0] status
);
  import nsd_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  cell_cmd_t              cmd;
  logic [CNT_W-1:0]       count;
  logic [POS_W-1:0]       cell_val [TABLE_DEPTH];
  logic                   cell_gt  [TABLE_DEPTH];
  logic [POS_W-1:0]       distance;
  logic [CNT_OUT_W-1:0]   stored_count;

  // pack result beat
  assign m_axis_tdata = {{(48 - POS_W - CNT_OUT_W){1'b0}}, stored_count, distance};

  nsd_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .distance     (distance),
    .stored_count (stored_count),
    .head_value   (cell_val[0]),
    .cmd          (cmd),
    .count        (count)
  );

  // chain of table cells, cell 0 is the head
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [POS_W-1:0] prev_value;
    logic             prev_gt;
    logic [POS_W-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_value = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_value = cell_val[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_inner
      assign next_value = cell_val[i+1];
    end

    nsd_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .prev_value(prev_value),
      .prev_gt   (prev_gt),
      .next_value(next_value),
      .head_value(cell_val[0]),
      .value     (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

endmodule

### tb/nearest_sorted_distance_top_tb.sv
`timescale 1ns / 1ps

module nearest_sorted_distance_top_tb;
  import nsd_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 750;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 40;

  // one answer beat as the table should produce it
  typedef struct {
    logic [POS_W-1:0]     distance;
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [POS_W-1:0]  s_axis_tdata = '0;
  logic [ACT_W-1:0]  s_axis_tuser = ACT_CLEAR;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  nearest_sorted_distance_top #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the sorted table
  logic [POS_W-1:0] pos_table [DEPTH];
  int held = 0;
  answer_t awaited_answers [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_empty = 0;
  int n_dropped = 0;
  int n_answers = 0;
  int max_held = 0;
  int cycles = 0;

  // apply one item to the mirror and return the answer it should give
  function automatic answer_t predict_answer(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos);
    answer_t a;
    int idx;
    logic [POS_W-1:0] gap;
    logic [POS_W-1:0] best;
    a.distance = '0;
    a.status = ST_DONE;
    case (act)
      ACT_CLEAR: held = 0;
      ACT_INSERT: begin
        if (held >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          // new entry lands after any equal ones
          idx = held;
          while (idx > 0 && pos_table[idx-1] > pos) begin
            pos_table[idx] = pos_table[idx-1];
            idx--;
          end
          pos_table[idx] = pos;
          held++;
        end
      end
      ACT_QUERY: begin
        if (held == 0) begin
          a.status = ST_EMPTY;
        end else begin
          best = '1;
          for (int i = 0; i < held; i++) begin
            gap = (pos >= pos_table[i]) ? pos - pos_table[i] : pos_table[i] - pos;
            if (gap < best) best = gap;
          end
          a.distance = best;
        end
      end
      default: ;
    endcase
    a.count = CNT_OUT_W'(held);
    return a;
  endfunction

  // position to store: clustered around base, duplicates, extremes
  function automatic logic [POS_W-1:0] pick_entry(logic [POS_W-1:0] base);
    case ($urandom_range(7))
      0: return $urandom;
      1: return (held > 0) ? pos_table[$urandom_range(held-1)] : base;
      2: return $urandom_range(1) ? '1 : '0;
      default: return base + $urandom_range(4095);
    endcase
  endfunction

  // position to look up: on, near, between and far from stored entries
  function automatic logic [POS_W-1:0] pick_probe();
    int k;
    if (held == 0) return $urandom;
    k = $urandom_range(held-1);
    case ($urandom_range(6))
      0: return $urandom;
      1: return pos_table[k];
      2: return pos_table[k] + $urandom_range(8) - 4;
      3: begin
        // halfway point gives a tie when the gap is even
        if (k + 1 < held) return pos_table[k] + (pos_table[k+1] - pos_table[k]) / 2;
        return pos_table[k] + 1;
      end
      4: return $urandom_range(1) ? '1 : '0;
      default: return pos_table[k] ^ (32'h1 << $urandom_range(31));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    if (errors < MAX_PRINTED)
      $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // drive one beat, wait for the handshake, record the answer it owes
  task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos);
    answer_t a;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pos;
    s_axis_tuser <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    a = predict_answer(act, pos);
    awaited_answers = {awaited_answers, a};
    if (act != ACT_UNUSED) n_items++;
    if (act == ACT_QUERY) n_queries++;
    if (a.status == ST_EMPTY) n_empty++;
    if (a.status == ST_FULL) n_dropped++;
    if (held > max_held) max_held = held;
  endtask

  // hold the input until every owed answer is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  // extremes, ties, empty and unused-code cases
  task automatic test_directed();
    send_item(ACT_QUERY, 32'h0000_1234);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 32'd100);
    send_item(ACT_INSERT, 32'd300);
    send_item(ACT_QUERY, 32'd200);
    send_item(ACT_INSERT, 32'd100);
    send_item(ACT_QUERY, 32'd99);
    send_item(ACT_QUERY, 32'd301);
    send_item(ACT_UNUSED, 32'd5);
    send_item(ACT_INSERT, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 32'h0000_0000);
    send_item(ACT_QUERY, 32'h8000_0000);
    send_item(ACT_QUERY, 32'hFFFF_FFFE);
    send_item(ACT_CLEAR, 32'hA5A5_5A5A);
    send_item(ACT_QUERY, 32'h0);
    send_item(ACT_INSERT, 32'hFFFF_FFFF);
    send_item(ACT_QUERY, 32'h0);
    send_item(ACT_INSERT, 32'h0);
    send_item(ACT_QUERY, 32'h7FFF_FFFF);
    send_item(ACT_QUERY, 32'h8000_0000);
    send_item(ACT_CLEAR, 32'h0);
    send_item(ACT_INSERT, 32'h5555_5555);
    send_item(ACT_QUERY, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  // fill the table to capacity, then overflow it
  task automatic test_full_table();
    logic [POS_W-1:0] base;
    base = $urandom;
    send_item(ACT_CLEAR, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(ACT_INSERT, pick_entry(base));
    end
    repeat (4) send_item(ACT_QUERY, pick_probe());
    send_item(ACT_INSERT, $urandom);
    send_item(ACT_INSERT, 32'h0);
    send_item(ACT_UNUSED, $urandom);
    send_item(ACT_QUERY, 32'hFFFF_FFFF);
    send_item(ACT_CLEAR, $urandom);
    send_item(ACT_QUERY, $urandom);
    wait_drained();
  endtask

  // load-then-query runs with random content, mixed with stray items
  task automatic test_random_traffic(int tx_pct, int rx_pct, int quota);
    int start;
    int n_ins;
    logic [POS_W-1:0] base;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = n_items;
    while (n_items - start < quota) begin
      if ($urandom_range(99) < 80) begin
        if (held > 100 || $urandom_range(3) != 0) send_item(ACT_CLEAR, $urandom);
        n_ins = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
        base = $urandom;
        repeat (n_ins) send_item(ACT_INSERT, pick_entry(base));
        repeat ($urandom_range(1, 16)) send_item(ACT_QUERY, pick_probe());
      end else begin
        send_item(ACT_W'($urandom_range(3)), $urandom);
      end
      if ($urandom_range(99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // compare each answer beat with the oldest owed answer
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_answers++;
      if (awaited_answers.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata[31:0], '0);
      end else begin
        want = awaited_answers.pop_front();
        if (m_axis_tdata[31:0] != want.distance)
          report_mismatch("distance", m_axis_tdata[31:0], want.distance);
        if (m_axis_tuser != want.status)
          report_mismatch("status", POS_W'(m_axis_tuser), POS_W'(want.status));
        if (m_axis_tdata[42:32] != want.count)
          report_mismatch("stored_count", POS_W'(m_axis_tdata[42:32]), POS_W'(want.count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_sorted_distance_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    tx_idle_pct = 12;
    rx_idle_pct = 76;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_random_traffic(12, 76, RAND_ITEMS / 3);
    test_random_traffic(76, 12, RAND_ITEMS / 3);
    test_random_traffic(0, 0, RAND_ITEMS / 3);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d items, %0d queries (%0d on empty table), %0d inserts dropped when full",
             n_items, n_queries, n_empty, n_dropped);
    $display("Checked %0d result beats, table held up to %0d entries, %0d mismatches",
             n_answers, max_held, errors);
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("nearest_sorted_distance_top_tb OK");
    end else begin
      $display("nearest_sorted_distance_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
src/nsd_pkg.sv
src/nsd_cell.sv
src/nsd_ctrl.sv
src/nearest_sorted_distance_top.sv
tb/nearest_sorted_distance_top_tb.sv
